>>> hw/rtl/mps_pkg.sv
// Shared types, constants and helpers of the multilevel priority scheduler.
// No dependencies; every other file but mps_ram refers to it by scoped names.
package mps_pkg;

    localparam int LEVELS         = 8;
    localparam int LEVEL_DEPTH    = 16;
    localparam int PRIO_PER_LEVEL = 4;

    localparam int SLOTS   = LEVELS * LEVEL_DEPTH;
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int HEAD_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int DYN_MAX = 31;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_REQUEUE  = 2'd1;
    localparam logic [1:0] OP_SCHEDULE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [7:0] id;
        logic [4:0] base;
        logic [7:0] cpu;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic capture;
        logic exec;
        logic sweep_step;
        logic pop_read;
        logic pop_take;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
    } stat_t;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                     input logic [HEAD_W-1:0] slot);
        logic [ADDR_W-1:0] base_addr;
        base_addr = ADDR_W'(lvl) * ADDR_W'(LEVEL_DEPTH);
        return base_addr + ADDR_W'(slot);
    endfunction

endpackage

>>> hw/rtl/mps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/mps_datapath.sv
// Datapath: entry RAM, per-level head and count registers, decay sweep, result.
// Depends on mps_pkg and mps_ram.
module mps_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  mps_pkg::cmd_t     cmd,
    output mps_pkg::stat_t    stat,
    input  logic [1:0]        operation,
    input  logic [7:0]        task_id,
    input  logic [4:0]        base_priority,
    input  logic [4:0]        given_dynamic,
    input  logic [7:0]        cpu_used,
    output logic [1:0]        status,
    output logic              chosen_valid,
    output logic [7:0]        chosen_id,
    output logic [4:0]        chosen_priority,
    output logic [7:0]        chosen_cpu,
    output logic [2:0]        chosen_level
);

    logic [1:0]                  op_reg;
    logic [7:0]                  id_reg;
    logic [4:0]                  base_reg;
    logic [4:0]                  given_reg;
    logic [7:0]                  cpu_reg;

    logic [mps_pkg::HEAD_W-1:0]  heads_reg  [mps_pkg::LEVELS];
    logic [mps_pkg::CNT_W-1:0]   counts_reg [mps_pkg::LEVELS];
    logic [mps_pkg::LEVELS-1:0]  nonempty_reg;

    logic [mps_pkg::ADDR_W-1:0]  idx_reg;
    logic                        wb_pending_reg;
    logic [mps_pkg::ADDR_W-1:0]  wb_addr_reg;
    logic [mps_pkg::LVL_W-1:0]   pop_lvl_reg;
    logic                        pop_found_reg;

    logic [1:0]                  res_status_reg;
    logic                        res_valid_reg;
    mps_pkg::entry_t             res_entry_reg;
    logic [mps_pkg::LVL_W-1:0]   res_lvl_reg;

    logic [7:0]                  dyn_sum;
    logic [4:0]                  dyn;
    logic [4:0]                  lvl_raw;
    logic [mps_pkg::LVL_W-1:0]   enq_lvl;
    logic [mps_pkg::LVL_W-1:0]   sel_lvl;
    logic                        sel_found;
    logic [mps_pkg::LVL_W-1:0]   cur_lvl;
    logic [mps_pkg::HEAD_W-1:0]  cur_head;
    logic [mps_pkg::CNT_W-1:0]   cur_count;
    logic [mps_pkg::CNT_W:0]     tail_sum;
    logic [mps_pkg::HEAD_W-1:0]  tail_slot;
    logic [mps_pkg::HEAD_W-1:0]  head_inc;
    logic                        enq_ok;
    logic                        enq_op;

    logic                        ram_we;
    logic [mps_pkg::ADDR_W-1:0]  ram_waddr;
    mps_pkg::entry_t             ram_wdata;
    logic [mps_pkg::ADDR_W-1:0]  ram_raddr;
    mps_pkg::entry_t             ram_rdata;

    always_comb
    begin
        dyn_sum = 8'(base_reg) + 8'(cpu_reg[7:1]);
        if (op_reg == mps_pkg::OP_ADD)
        begin
            dyn = (given_reg == 5'd0) ? base_reg : given_reg;
        end
        else if (dyn_sum > 8'(mps_pkg::DYN_MAX))
        begin
            dyn = 5'(mps_pkg::DYN_MAX);
        end
        else
        begin
            dyn = dyn_sum[4:0];
        end
        lvl_raw = 5'(dyn / mps_pkg::PRIO_PER_LEVEL);
        if (lvl_raw > 5'(mps_pkg::LEVELS - 1))
        begin
            enq_lvl = mps_pkg::LVL_W'(mps_pkg::LEVELS - 1);
        end
        else
        begin
            enq_lvl = mps_pkg::LVL_W'(lvl_raw);
        end
    end

    always_comb
    begin
        sel_lvl   = '0;
        sel_found = 1'b0;
        for (int l = mps_pkg::LEVELS - 1; l >= 0; l--)
        begin
            if (nonempty_reg[l])
            begin
                sel_lvl   = mps_pkg::LVL_W'(l);
                sel_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        priority if (cmd.pop_read)
        begin
            cur_lvl = sel_lvl;
        end
        else if (cmd.pop_take)
        begin
            cur_lvl = pop_lvl_reg;
        end
        else
        begin
            cur_lvl = enq_lvl;
        end
        cur_head  = heads_reg[cur_lvl];
        cur_count = counts_reg[cur_lvl];
        tail_sum  = (mps_pkg::CNT_W + 1)'(cur_head) + (mps_pkg::CNT_W + 1)'(cur_count);
        if (tail_sum >= (mps_pkg::CNT_W + 1)'(mps_pkg::LEVEL_DEPTH))
        begin
            tail_slot = mps_pkg::HEAD_W'(tail_sum - (mps_pkg::CNT_W + 1)'(mps_pkg::LEVEL_DEPTH));
        end
        else
        begin
            tail_slot = mps_pkg::HEAD_W'(tail_sum);
        end
        if ((mps_pkg::CNT_W + 1)'(cur_head) == (mps_pkg::CNT_W + 1)'(mps_pkg::LEVEL_DEPTH - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = cur_head + mps_pkg::HEAD_W'(1);
        end
        enq_op = (op_reg == mps_pkg::OP_ADD) || (op_reg == mps_pkg::OP_REQUEUE);
        enq_ok = cur_count < mps_pkg::CNT_W'(mps_pkg::LEVEL_DEPTH);
    end

    always_comb
    begin
        if (wb_pending_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = wb_addr_reg;
            ram_wdata = ram_rdata;
            ram_wdata.cpu = {1'b0, ram_rdata.cpu[7:1]};
        end
        else
        begin
            ram_we    = cmd.exec && enq_op && enq_ok;
            ram_waddr = mps_pkg::slot_addr(cur_lvl, tail_slot);
            ram_wdata = '{id: id_reg, base: base_reg, cpu: cpu_reg};
        end
        ram_raddr = cmd.pop_read ? mps_pkg::slot_addr(cur_lvl, cur_head) : idx_reg;
    end

    mps_ram #(
        .WIDTH(mps_pkg::ENTRY_W),
        .DEPTH(mps_pkg::SLOTS)
    ) u_entries (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign stat.sweep_last = (idx_reg == mps_pkg::ADDR_W'(mps_pkg::SLOTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < mps_pkg::LEVELS; l++)
            begin
                heads_reg[l]  <= '0;
                counts_reg[l] <= '0;
            end
            nonempty_reg   <= '0;
            wb_pending_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            wb_pending_reg <= cmd.sweep_step;
            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            else if (cmd.sweep_step && !stat.sweep_last)
            begin
                idx_reg <= idx_reg + mps_pkg::ADDR_W'(1);
            end
            if (cmd.exec && enq_op && enq_ok)
            begin
                counts_reg[cur_lvl]   <= cur_count + mps_pkg::CNT_W'(1);
                nonempty_reg[cur_lvl] <= 1'b1;
            end
            if (cmd.pop_take && pop_found_reg)
            begin
                heads_reg[cur_lvl]  <= head_inc;
                counts_reg[cur_lvl] <= cur_count - mps_pkg::CNT_W'(1);
                if (cur_count == mps_pkg::CNT_W'(1))
                begin
                    nonempty_reg[cur_lvl] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wb_addr_reg <= idx_reg;
        if (cmd.capture)
        begin
            op_reg    <= operation;
            id_reg    <= task_id;
            base_reg  <= base_priority;
            given_reg <= given_dynamic;
            cpu_reg   <= cpu_used;
        end
        if (cmd.pop_read)
        begin
            pop_lvl_reg   <= sel_lvl;
            pop_found_reg <= sel_found;
        end
        if (cmd.exec)
        begin
            res_valid_reg <= 1'b0;
            res_entry_reg <= '0;
            if (enq_op)
            begin
                res_status_reg <= enq_ok ? mps_pkg::ST_OK : mps_pkg::ST_FULL;
                res_lvl_reg    <= cur_lvl;
            end
            else
            begin
                res_status_reg <= mps_pkg::ST_OK;
                res_lvl_reg    <= '0;
            end
        end
        if (cmd.pop_take)
        begin
            if (pop_found_reg)
            begin
                res_status_reg <= mps_pkg::ST_OK;
                res_valid_reg  <= 1'b1;
                res_entry_reg  <= ram_rdata;
                res_lvl_reg    <= pop_lvl_reg;
            end
            else
            begin
                res_status_reg <= mps_pkg::ST_EMPTY;
                res_valid_reg  <= 1'b0;
                res_entry_reg  <= '0;
                res_lvl_reg    <= '0;
            end
        end
        if (cmd.out_load)
        begin
            status          <= res_status_reg;
            chosen_valid    <= res_valid_reg;
            chosen_id       <= res_entry_reg.id;
            chosen_priority <= res_entry_reg.base;
            chosen_cpu      <= res_entry_reg.cpu;
            chosen_level    <= 3'(res_lvl_reg);
        end
    end

endmodule

>>> hw/rtl/mps_ctrl.sv
// Controller: sequences capture, enqueue, decay sweep, pop and result transfer.
// Depends on mps_pkg.
module mps_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     operation,
    output logic           out_valid,
    input  logic           out_stall,
    input  mps_pkg::stat_t stat,
    output mps_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DECAY,
        S_DRAIN,
        S_POP_RD,
        S_POP_DATA,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.capture    = (state_reg == S_IDLE) && in_valid;
        cmd.exec       = (state_reg == S_EXEC);
        cmd.sweep_step = (state_reg == S_DECAY);
        cmd.pop_read   = (state_reg == S_POP_RD);
        cmd.pop_take   = (state_reg == S_POP_DATA);
        cmd.out_load   = (state_reg == S_HOLD) && out_free;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (operation == mps_pkg::OP_SCHEDULE) ? S_DECAY : S_EXEC;
                end
            end
            S_EXEC:     state_next = S_HOLD;
            S_DECAY:
            begin
                if (stat.sweep_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:    state_next = S_POP_RD;
            S_POP_RD:   state_next = S_POP_DATA;
            S_POP_DATA: state_next = S_HOLD;
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
        out_valid_next = cmd.out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/multilevel_priority_scheduler.sv
// Multilevel priority scheduler with per-level FIFO ready queues and cpu decay.
// An add or requeue passes through the execute state to the result; a schedule
// first runs the decay sweep, which reads and rewrites every slot of the entry
// RAM through its single read port, and then pops an entry.
// One item is in work at a time; a finished result waits in the output register.
// Depends on mps_pkg, mps_ctrl, mps_datapath and mps_ram.
module multilevel_priority_scheduler (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [7:0] task_id,
    input  logic [4:0] base_priority,
    input  logic [4:0] given_dynamic,
    input  logic [7:0] cpu_used,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic       chosen_valid,
    output logic [7:0] chosen_id,
    output logic [4:0] chosen_priority,
    output logic [7:0] chosen_cpu,
    output logic [2:0] chosen_level
);

    mps_pkg::cmd_t  cmd;
    mps_pkg::stat_t stat;

    mps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .operation(operation),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mps_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .operation      (operation),
        .task_id        (task_id),
        .base_priority  (base_priority),
        .given_dynamic  (given_dynamic),
        .cpu_used       (cpu_used),
        .status         (status),
        .chosen_valid   (chosen_valid),
        .chosen_id      (chosen_id),
        .chosen_priority(chosen_priority),
        .chosen_cpu     (chosen_cpu),
        .chosen_level   (chosen_level)
    );

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while previous item still in work");

    a_chosen_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chosen_valid |-> status == mps_pkg::ST_OK)
        else $error("picked task reported with non-ok status");

    a_empty_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == mps_pkg::ST_EMPTY |->
            !chosen_valid && chosen_id == 8'd0 && chosen_level == 3'd0)
        else $error("nothing-ready result carries task fields");

endmodule
